>>> rtl/mtsi_pkg.sv
// ----------------------------------------------------------------------------
// mtsi_pkg
// Shared types, constants and the sigmoid table of the two-input perceptron.
// ----------------------------------------------------------------------------
package mtsi_pkg;

  localparam int NEURONS_DEF  = 8;
  localparam int DATA_W       = 16;
  localparam int IDX_W        = 5;
  localparam int EST_W        = 24;
  localparam int SIG_W        = 13;   // unsigned Q1.12, 0..4096
  localparam int TAB_DEPTH    = 256;
  localparam int ONE_Q12      = 4096;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;  // exp(-1/32) in Q32

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Weights of one hidden neuron, as they travel along the cell chain
  typedef struct packed {
    logic signed [DATA_W-1:0] w_first;
    logic signed [DATA_W-1:0] w_second;
    logic signed [DATA_W-1:0] bias;
    logic signed [DATA_W-1:0] w_out;
  } weight_set_t;

  // Chain control: rotate or take one weight write
  typedef struct packed {
    logic                     shift;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic signed [DATA_W-1:0] wr_val;
  } cell_ctrl_t;

  // Datapath control
  typedef struct packed {
    logic issue;
    logic last;
    logic clear;
  } dp_ctrl_t;

  typedef logic [TAB_DEPTH-1:0][SIG_W-1:0] sig_tab_t;

  // Builds the table at elaboration: upper half by rounded division with a
  // shift-subtract loop, lower half mirrored around one.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t     tab;
    logic [63:0]  p;
    logic [63:0]  den;
    logic [63:0]  rem;
    logic [127:0] prod;
    logic [SIG_W-1:0] s;
    p = EXP_STEP_Q32;
    for (int k = 0; k < TAB_DEPTH / 2; k++) begin
      den = 64'h1_0000_0000 + p;
      rem = (64'd1 << 44) + (den >> 1);
      s   = '0;
      for (int b = SIG_W - 1; b >= 0; b--) begin
        if (rem >= (den << b)) begin
          rem  = rem - (den << b);
          s[b] = 1'b1;
        end
      end
      tab[TAB_DEPTH/2 + k]     = s;
      tab[TAB_DEPTH/2 - 1 - k] = SIG_W'(ONE_Q12) - s;
      prod = {64'd0, p} * {64'd0, EXP_STEP_Q32} + 128'd2147483648;
      p    = prod[95:32];
      prod = {64'd0, p} * {64'd0, EXP_STEP_Q32} + 128'd2147483648;
      p    = prod[95:32];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

>>> rtl/mtsi_if.sv
// ----------------------------------------------------------------------------
// mtsi_if
// Valid/ready channels: input item and result beat.
// ----------------------------------------------------------------------------
interface mtsi_in_if
  import mtsi_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] x_first;
  logic signed [DATA_W-1:0] x_second;
  logic [IDX_W-1:0]         weight_index;
  logic signed [DATA_W-1:0] weight_value;

  modport source (output valid, mode, x_first, x_second, weight_index, weight_value,
                  input ready);
  modport sink   (input valid, mode, x_first, x_second, weight_index, weight_value,
                  output ready);
endinterface

interface mtsi_out_if
  import mtsi_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;

  modport source (output valid, estimate, input ready);
  modport sink   (input valid, estimate, output ready);
endinterface

>>> rtl/mlp_two_input_sigmoid_inference.sv
// ----------------------------------------------------------------------------
// mlp_two_input_sigmoid_inference
// Load item: written into its weight cell on accept, no result; loads may arrive
// back to back. Compute item: the ring of weight cells rotates once per neuron
// into one shared MAC/sigmoid pipe, and the result beat is registered once the
// last neuron has drained; the next item is taken only after that result is
// loaded, later while the previous result beat still waits for ready.
// Async active-low reset clears control only; weights are undefined until loaded.
// ----------------------------------------------------------------------------
module mlp_two_input_sigmoid_inference
  import mtsi_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  mtsi_in_if.sink    in_i,
  mtsi_out_if.source out_o
);

  localparam int CNT_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic                     accept;
  logic                     run_acc;
  logic signed [DATA_W-1:0] x_first_q, x_second_q;

  logic                     out_valid_q, out_valid_d;
  logic signed [EST_W-1:0]  est_q;
  logic                     load_out;

  cell_ctrl_t  cell_ctrl;
  dp_ctrl_t    dp_ctrl;
  weight_set_t ring [NEURONS];
  logic                     dp_done;
  logic signed [EST_W-1:0]  dp_est;

  // Items are taken only while the pipe is empty; result sits in its own register
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign run_acc    = accept & ~in_i.mode;

  // Weight ring: cell n shifts from cell n+1, last cell wraps from cell 0.
  // After NEURONS shifts every set is back in its home cell.
  assign cell_ctrl.shift  = (state_q == ST_ISSUE);
  assign cell_ctrl.wr_en  = accept & in_i.mode;
  assign cell_ctrl.wr_idx = in_i.weight_index;
  assign cell_ctrl.wr_val = in_i.weight_value;

  for (genvar n = 0; n < NEURONS; n++) begin : g_cell
    mtsi_cell #(
      .NEURONS  (NEURONS),
      .CELL_IDX (n)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .nb_i   (ring[(n + 1) % NEURONS]),
      .w_o    (ring[n])
    );
  end

  // Cell 0 feeds the shared pipe each issue cycle
  assign dp_ctrl.issue = (state_q == ST_ISSUE);
  assign dp_ctrl.last  = (cnt_q == CNT_W'(NEURONS - 1));
  assign dp_ctrl.clear = run_acc;

  mtsi_datapath #(
    .NEURONS (NEURONS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dp_ctrl),
    .x_first_i  (x_first_q),
    .x_second_i (x_second_q),
    .w_i        (ring[0]),
    .done_o     (dp_done),
    .estimate_o (dp_est)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_acc) begin
      x_first_q  <= in_i.x_first;
      x_second_q <= in_i.x_second;
    end
    if (load_out) begin
      est_q <= dp_est;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (run_acc) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cnt_q == CNT_W'(NEURONS - 1)) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (dp_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the previous result beat to leave
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (load_out)                   out_valid_d = 1'b1;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = est_q;

  // A compute beat starts the issue phase
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_acc |=> state_q == ST_ISSUE)
    else $error("compute beat did not start issue");

  // A load beat leaves the pipe idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode) |=> state_q == ST_IDLE)
    else $error("load beat left idle");

  // Last neuron reaches the accumulator only while draining
  a_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_done |-> state_q == ST_DRAIN)
    else $error("accumulator finished outside drain");

  // Issue counter never runs past the last neuron
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |-> cnt_q <= CNT_W'(NEURONS - 1))
    else $error("issue counter overrun");

  // A new result appears only out of the finish step
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q) == ST_FINISH)
    else $error("result beat without finish");

endmodule

>>> rtl/mtsi_cell.sv
// ----------------------------------------------------------------------------
// mtsi_cell
// One link of the weight ring: holds one neuron's four weights.
// ----------------------------------------------------------------------------
module mtsi_cell
  import mtsi_pkg::*;
#(
  parameter int NEURONS  = NEURONS_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic        clk_i,
  input  cell_ctrl_t  ctrl_i,
  input  weight_set_t nb_i,
  output weight_set_t w_o
);

  localparam int SLOT_W = 8;

  weight_set_t w_q;
  logic [SLOT_W-1:0] slot;

  assign slot = {{(SLOT_W-IDX_W){1'b0}}, ctrl_i.wr_idx};

  // Writes only land while the ring sits at home, so this cell owns neuron CELL_IDX
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      w_q <= nb_i;
    end else if (ctrl_i.wr_en) begin
      if (slot == SLOT_W'(CELL_IDX))             w_q.w_first  <= ctrl_i.wr_val;
      if (slot == SLOT_W'(NEURONS + CELL_IDX))   w_q.w_second <= ctrl_i.wr_val;
      if (slot == SLOT_W'(2*NEURONS + CELL_IDX)) w_q.bias     <= ctrl_i.wr_val;
      if (slot == SLOT_W'(3*NEURONS + CELL_IDX)) w_q.w_out    <= ctrl_i.wr_val;
    end
  end

  assign w_o = w_q;

endmodule

>>> rtl/mtsi_datapath.sv
// ----------------------------------------------------------------------------
// mtsi_datapath
// Shared neuron pipeline: products, hidden sum, sigmoid, output MAC.
// ----------------------------------------------------------------------------
module mtsi_datapath
  import mtsi_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_ctrl_t                 ctrl_i,
  input  logic signed [DATA_W-1:0] x_first_i,
  input  logic signed [DATA_W-1:0] x_second_i,
  input  weight_set_t              w_i,
  output logic                     done_o,
  output logic signed [EST_W-1:0]  estimate_o
);

  localparam int PROD_W = 2 * DATA_W;                 // 32
  localparam int SUM_W  = PROD_W + 2;                 // 34, exact Q.24
  localparam int HI_W   = SUM_W - 20;                 // sum in steps of 1/16, the table bin
  localparam int OUT_W  = SIG_W + 1 + DATA_W;         // 30
  localparam int ACC_W  = OUT_W + $clog2(NEURONS) + 1;
  localparam int EXT_W  = 48;

  // stage 1
  logic                     v1_q, l1_q;
  logic signed [PROD_W-1:0] p0_q, p1_q;
  logic signed [DATA_W-1:0] bias1_q, wout1_q;
  // stage 2
  logic                     v2_q, l2_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] wout2_q;
  // stage 3
  logic                     v3_q, l3_q;
  logic [SIG_W-1:0]         sig_q;
  logic signed [DATA_W-1:0] wout3_q;
  // stage 4
  logic                     v4_q, l4_q;
  logic signed [OUT_W-1:0]  prod_q;
  // accumulator
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;

  logic signed [SUM_W-1:0]  sum_d;
  logic signed [HI_W-1:0]   sum_hi;
  logic [SIG_W-1:0]         sig_d;
  logic signed [EXT_W-1:0]  rnd;
  logic signed [EXT_W-1:0]  est_full;

  assign sum_d = SUM_W'(p0_q) + SUM_W'(p1_q) + (SUM_W'(bias1_q) <<< 12);
  assign sum_hi = sum_q[SUM_W-1:20];

  // Table covers [-8,8); outside it the sigmoid saturates
  always_comb begin
    if (sum_hi < -HI_W'(128)) begin
      sig_d = '0;
    end else if (sum_hi > HI_W'(127)) begin
      sig_d = SIG_W'(ONE_Q12);
    end else begin
      sig_d = SIG_TABLE[{~sum_hi[7], sum_hi[6:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      l1_q   <= 1'b0;
      l2_q   <= 1'b0;
      l3_q   <= 1'b0;
      l4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= ctrl_i.issue;
      l1_q   <= ctrl_i.issue & ctrl_i.last;
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      v3_q   <= v2_q;
      l3_q   <= l2_q;
      v4_q   <= v3_q;
      l4_q   <= l3_q;
      done_q <= v4_q & l4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= x_first_i * w_i.w_first;
    p1_q    <= x_second_i * w_i.w_second;
    bias1_q <= w_i.bias;
    wout1_q <= w_i.w_out;
    sum_q   <= sum_d;
    wout2_q <= wout1_q;
    sig_q   <= sig_d;
    wout3_q <= wout2_q;
    prod_q  <= $signed({1'b0, sig_q}) * wout3_q;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (v4_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up to Q12.12, then saturate
  assign rnd      = EXT_W'(acc_q) + EXT_W'(2048);
  assign est_full = rnd >>> 12;

  always_comb begin
    if (est_full > EXT_W'(8388607)) begin
      estimate_o = EST_W'(8388607);
    end else if (est_full < -EXT_W'(8388608)) begin
      estimate_o = EST_W'(-8388608);
    end else begin
      estimate_o = est_full[EST_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-input sigmoid perceptron. Weight loads and
// forward passes stream in over valid/ready; each estimate beat is compared
// against a bit-exact fixed-point prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import mtsi_pkg::*;

  localparam int N            = NEURONS_DEF;
  localparam int SLOTS        = 4 * N;          // w0 | w1 | bias | w_out
  localparam int RANDOM_ITEMS = 610;
  localparam int DRAIN_EVERY  = 150;            // forced full drain period
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic signed [DATA_W-1:0] Q12_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] Q12_MIN = 16'sh8000;

  typedef enum logic {
    MODE_COMPUTE = 1'b0,
    MODE_LOAD    = 1'b1
  } mode_e;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [DATA_W-1:0] x_first;
    logic signed [DATA_W-1:0] x_second;
    logic [IDX_W-1:0]         weight_index;
    logic signed [DATA_W-1:0] weight_value;
  } item_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the weight store, predicts each estimate on accept,
  // and checks result beats in order.
  // --------------------------------------------------------------------------
  class estimate_scoreboard;
    logic signed [DATA_W-1:0] weights [SLOTS];
    logic [SIG_W-1:0]         sig_lut [TAB_DEPTH];
    logic signed [EST_W-1:0]  expected_est [$];
    int errors;
    int checked;
    int loads;
    int passes;

    function new();
      longint unsigned p;
      longint unsigned den;
      longint unsigned s;
      // upper half by rounded division, lower half mirrored around one;
      // p walks the odd powers of exp(-1/32) in Q32
      p = EXP_STEP_Q32;
      for (int k = 0; k < TAB_DEPTH / 2; k++) begin
        den = 64'h1_0000_0000 + p;
        s   = ((64'd1 << 44) + den / 2) / den;
        sig_lut[TAB_DEPTH/2 + k]     = SIG_W'(s);
        sig_lut[TAB_DEPTH/2 - 1 - k] = SIG_W'(ONE_Q12 - s);
        repeat (2) p = (p * EXP_STEP_Q32 + 64'd2147483648) >> 32;
      end
      foreach (weights[i]) weights[i] = '0;
      errors  = 0;
      checked = 0;
      loads   = 0;
      passes  = 0;
    endfunction

    // bin = floor(sum / 2^20) + 128; clamps to 0 / one outside [-8,8)
    function int sigmoid_q12(longint sum);
      longint bin;
      bin = (sum >>> 20) + TAB_DEPTH / 2;
      if (bin < 0) return 0;
      if (bin >= TAB_DEPTH) return ONE_Q12;
      return int'(sig_lut[bin]);
    endfunction

    function logic signed [EST_W-1:0] forward_pass(longint x0, longint x1);
      longint acc;
      longint sum;
      longint est;
      acc = 0;
      for (int n = 0; n < N; n++) begin
        sum = x0 * longint'(weights[n]) + x1 * longint'(weights[N + n])
            + longint'(weights[2 * N + n]) * 4096;
        acc += longint'(sigmoid_q12(sum)) * longint'(weights[3 * N + n]);
      end
      est = (acc + 2048) >>> 12;   // Q24 -> Q12.12, round half up
      if (est > 8388607) est = 8388607;
      if (est < -8388608) est = -8388608;
      return est[EST_W-1:0];
    endfunction

    function void note_item(item_t it);
      if (it.mode == MODE_LOAD) begin
        if (int'(it.weight_index) < SLOTS) weights[it.weight_index] = it.weight_value;
        loads++;
      end else begin
        expected_est.push_back(forward_pass(it.x_first, it.x_second));
        passes++;
      end
    endfunction

    function void check_estimate(logic signed [EST_W-1:0] got);
      logic signed [EST_W-1:0] want;
      if (expected_est.size() == 0) begin
        errors++;
        $display("%0t: estimate beat with nothing expected, expected none, actual %0d",
                 $time, got);
        return;
      end
      want = expected_est.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: estimate mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_est.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  int unsigned cycle_cnt = 0;

  mtsi_in_if  in_if ();
  mtsi_out_if out_if ();

  estimate_scoreboard sb;

  mlp_two_input_sigmoid_inference #(
    .NEURONS (N)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost estimate ends up here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d estimates still owed",
               $time, cycle_cnt, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Beat monitor. Samples at the rising edge, before the block's registers
  // update. The result is checked before the input is noted, so a result and
  // a new item on the same edge keep their order.
  always @(posedge clk_i) begin : beat_monitor
    item_t seen;
    if (rst_ni === 1'b1) begin
      if (out_if.valid && out_if.ready) sb.check_estimate(out_if.estimate);
      if (in_if.valid && in_if.ready) begin
        seen.mode         = mode_e'(in_if.mode);
        seen.x_first      = in_if.x_first;
        seen.x_second     = in_if.x_second;
        seen.weight_index = in_if.weight_index;
        seen.weight_value = in_if.weight_value;
        sb.note_item(seen);
      end
    end
  end

  // Result-side backpressure: segments of random length, each with its own
  // stall style, including stretches of constant ready.
  initial begin : result_backpressure
    stall_e style;
    int     seg_len;
    @(posedge rst_ni);
    forever begin
      style   = stall_e'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 200);
      repeat (seg_len) begin
        @(negedge clk_i);
        case (style)
          STALL_NONE:  out_if.ready <= 1'b1;
          STALL_HALF:  out_if.ready <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY: out_if.ready <= ($urandom_range(0, 7) == 0);
          default:     out_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All drive at the falling edge; push_item returns at the
  // falling edge after its accept beat so the next item can follow directly.
  // --------------------------------------------------------------------------
  task automatic push_item(input item_t it);
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.x_first      <= it.x_first;
    in_if.x_second     <= it.x_second;
    in_if.weight_index <= it.weight_index;
    in_if.weight_value <= it.weight_value;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // unused fields carry junk; the block must ignore them
  function automatic item_t load_item(input int slot_idx, input int val);
    item_t it;
    it.mode         = MODE_LOAD;
    it.weight_index = IDX_W'(slot_idx);
    it.weight_value = DATA_W'(val);
    it.x_first      = DATA_W'($urandom);
    it.x_second     = DATA_W'($urandom);
    return it;
  endfunction

  function automatic item_t compute_item(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b);
    item_t it;
    it.mode         = MODE_COMPUTE;
    it.x_first      = a;
    it.x_second     = b;
    it.weight_index = IDX_W'($urandom);
    it.weight_value = DATA_W'($urandom);
    return it;
  endfunction

  // Mostly values within +-1.0 so hidden sums land inside the table's range;
  // some full-range values and a few corner values.
  function automatic logic signed [DATA_W-1:0] pick_q12();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = DATA_W'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0:       v = Q12_MAX;
          1:       v = Q12_MIN;
          2:       v = '0;
          3:       v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      default: v = DATA_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
    return v;
  endfunction

  task automatic set_uniform(input int w_in0, input int w_in1, input int b, input int w_o);
    for (int n = 0; n < N; n++) begin
      push_item(load_item(n, w_in0));
      push_item(load_item(N + n, w_in1));
      push_item(load_item(2 * N + n, b));
      push_item(load_item(3 * N + n, w_o));
    end
  endtask

  task automatic load_random_store();
    for (int i = 0; i < SLOTS; i++) push_item(load_item(i, pick_q12()));
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    int drain_mark;

    sb = new();
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_COMPUTE;
    in_if.x_first      = '0;
    in_if.x_second     = '0;
    in_if.weight_index = '0;
    in_if.weight_value = '0;
    out_if.ready       = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every slot is written before the first forward pass
    load_random_store();

    // input extremes on random weights
    push_item(compute_item(Q12_MAX, Q12_MAX));
    push_item(compute_item(Q12_MIN, Q12_MIN));
    push_item(compute_item(Q12_MAX, Q12_MIN));
    push_item(compute_item('0, '0));

    // table edges: w0 = 4.0, so x0 = +-2.0 puts the sum exactly on +-8
    set_uniform(16384, 0, 0, 32767);
    push_item(compute_item(16'sd8192, Q12_MAX));    // sum = +8, saturates to one
    push_item(compute_item(16'sd8191, Q12_MIN));    // top bin
    push_item(compute_item('0, '0));                // sum = 0, middle bin
    push_item(compute_item(-16'sd1, '0));           // just below zero
    push_item(compute_item(-16'sd8192, Q12_MAX));   // sum = -8, bottom bin
    push_item(compute_item(-16'sd8193, Q12_MIN));   // below -8, zero

    // full-scale weights in every slot, corners of the inputs
    set_uniform(32767, -32768, 32767, -32768);
    push_item(compute_item(Q12_MAX, Q12_MAX));
    push_item(compute_item(Q12_MIN, Q12_MAX));
    push_item(compute_item(Q12_MAX, Q12_MIN));
    push_item(compute_item(Q12_MIN, Q12_MIN));

    // random phase: bursts with gaps, about one item in five a weight reload
    load_random_store();
    sent       = 0;
    drain_mark = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 4) == 0) begin
          push_item(load_item($urandom_range(0, SLOTS - 1), pick_q12()));
        end else begin
          push_item(compute_item(pick_q12(), pick_q12()));
        end
        sent++;
      end
      // hold off now and then until every estimate is back
      if (sent >= drain_mark) begin
        wait_drained();
        drain_mark += DRAIN_EVERY;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      idle_for(gap);
    end

    // drain, then a few pipeline depths to catch stray beats
    wait_drained();
    repeat (2 * (N + 6)) @(negedge clk_i);

    $display("Run covered %0d weight loads and %0d forward passes;", sb.loads, sb.passes);
    $display("%0d estimates compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mtsi_pkg.sv
rtl/mtsi_if.sv
rtl/mtsi_cell.sv
rtl/mtsi_datapath.sv
rtl/mlp_two_input_sigmoid_inference.sv
test/tb.sv
